FILE: hdl/unordered_key_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Unordered key table assertion macros
// Assertion shorthands for the key table unit; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef UNORDERED_KEY_TABLE_UNIT_MACROS_SVH
`define UNORDERED_KEY_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk and held off during reset.
`define UKT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on i_clk and held off during reset.
`define UKT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UKT_ASSERT_IMP(lbl, ante, cons, msg)
`define UKT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/ukt_pkg.sv
// ----------------------------------------------------------------------------
// Unordered key table package
// Field widths, request and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ukt_pkg;

    // Fixed field widths of the request and result beats.
    localparam int KEY_W         = 32;
    localparam int HANDLE_PORT_W = 16;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 5;
    localparam int FILL_W        = 6;

    // Default table shape.
    localparam int DEF_CAPACITY     = 32;
    localparam int DEF_HANDLE_WIDTH = 16;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_LIST   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Load and compare strobes for one cell; at most one load is set.
    typedef struct packed {
        logic cmp_en;
        logic load_ins;
        logic load_next;
        logic load_last;
    } t_cell_ctrl;

endpackage

FILE: hdl/ukt_cell.sv
// ----------------------------------------------------------------------------
// Unordered key table cell
// One table slot: holds a key and handle, compares against a request key,
// and loads from the request, its upper neighbor or the last slot.
// ----------------------------------------------------------------------------
module ukt_cell
    import ukt_pkg::*;
#(
    parameter int HS_W = DEF_HANDLE_WIDTH
) (
    input  logic                    i_clk,
    input  t_cell_ctrl              i_ctrl,
    input  logic                    i_occupied,
    input  logic signed [KEY_W-1:0] i_cmp_key,
    input  logic signed [KEY_W-1:0] i_ins_key,
    input  logic [HS_W-1:0]         i_ins_handle,
    input  logic signed [KEY_W-1:0] i_next_key,
    input  logic [HS_W-1:0]         i_next_handle,
    input  logic signed [KEY_W-1:0] i_last_key,
    input  logic [HS_W-1:0]         i_last_handle,
    output logic signed [KEY_W-1:0] o_key,
    output logic [HS_W-1:0]         o_handle,
    output logic                    o_match
);

    logic signed [KEY_W-1:0] r_key;
    logic [HS_W-1:0]         r_handle;
    logic                    r_match;

    // Slot contents: the loads are mutually exclusive.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_ins) begin
            r_key    <= i_ins_key;
            r_handle <= i_ins_handle;
        end else if (i_ctrl.load_next) begin
            r_key    <= i_next_key;
            r_handle <= i_next_handle;
        end else if (i_ctrl.load_last) begin
            r_key    <= i_last_key;
            r_handle <= i_last_handle;
        end
    end

    // Key compare, captured when a request beat is taken.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= i_occupied && (r_key == i_cmp_key);
        end
    end

    assign o_key    = r_key;
    assign o_handle = r_handle;
    assign o_match  = r_match;

endmodule

FILE: hdl/unordered_key_table_unit.sv
// ----------------------------------------------------------------------------
// Unordered key table unit
// Key/handle table built as a row of slot cells, filled in insertion order, with
// insert, lookup, remove (swap or shift) and list requests.
// ----------------------------------------------------------------------------
// A request beat is taken when i_start is high and o_busy is low. Insert,
// lookup and remove give one result beat: taking the request captures the
// key compare in every cell, then the execute state picks the first match,
// updates the row and registers the result. List gives one result beat per
// entry, one per cycle through the single read port over the row. Each
// result beat is on the o_ ports for exactly one cycle, marked by o_valid;
// the receiver cannot stall it, so it must take every beat as it comes.
// o_last marks the final beat of a request.
// ----------------------------------------------------------------------------
`include "unordered_key_table_unit_macros.svh"

module unordered_key_table_unit
    import ukt_pkg::*;
#(
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request channel
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [REQ_W-1:0]             i_req_type,
    input  logic signed [KEY_W-1:0]      i_key,
    input  logic [HANDLE_PORT_W-1:0]     i_record_handle,
    // Result channel
    output logic                         o_valid,
    output logic [STATUS_W-1:0]          o_status,
    output logic [POS_W-1:0]             o_position,
    output logic signed [KEY_W-1:0]      o_entry_key,
    output logic [HANDLE_PORT_W-1:0]     o_entry_handle,
    output logic [FILL_W-1:0]            o_fill_count,
    output logic                         o_last,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int HS_W  = (HANDLE_WIDTH < HANDLE_PORT_W) ? HANDLE_WIDTH : HANDLE_PORT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LIST = 3'b100
    } t_state;

    // Control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_mode;
    logic             r_valid, n_valid;

    // Request capture and result payload
    t_req                    r_req;
    logic signed [KEY_W-1:0] r_key;
    logic [HS_W-1:0]         r_handle;
    t_status                 r_status, n_status;
    logic [IDX_W-1:0]        r_pos, n_pos;
    logic signed [KEY_W-1:0] r_ekey, n_ekey;
    logic [HS_W-1:0]         r_ehandle, n_ehandle;
    logic [CNT_W-1:0]        r_fill, n_fill;
    logic                    r_last, n_last;

    // Row wiring
    t_cell_ctrl              w_ctrl [CAPACITY];
    logic signed [KEY_W-1:0] w_cell_key [CAPACITY];
    logic [HS_W-1:0]         w_cell_handle [CAPACITY];
    logic [CAPACITY-1:0]     w_match;
    logic [CAPACITY-1:0]     w_first;
    logic [CAPACITY-1:0]     w_from_hit;
    logic [IDX_W-1:0]        w_pos;
    logic [IDX_W-1:0]        w_last_idx;
    logic [IDX_W-1:0]        w_rd_idx;
    logic                    w_hit;
    logic                    w_full;
    logic                    w_accept;
    logic                    w_exec;
    logic                    w_do_ins;
    logic                    w_do_rem;
    logic                    w_cfg_wr;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_exec   = (r_state == S_EXEC);
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_hit    = |w_match;
    assign w_do_ins = w_exec && (r_req == REQ_INSERT) && !w_full;
    assign w_do_rem = w_exec && (r_req == REQ_REMOVE) && w_hit;

    // First matching slot as a one-hot vector, and every slot from it upward.
    assign w_first    = w_match & (~w_match + CAPACITY'(1));
    assign w_from_hit = ~(w_first - CAPACITY'(1));

    // Encode the first match position.
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end

    assign w_last_idx = IDX_W'(r_count - CNT_W'(1));
    assign w_rd_idx   = (r_state == S_LIST) ? r_idx : w_pos;

    // Row of slot cells, each below the top fed by its upper neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] w_nxt_key;
        logic [HS_W-1:0]         w_nxt_handle;

        if (g == CAPACITY - 1) begin : g_top
            assign w_nxt_key    = w_cell_key[g];
            assign w_nxt_handle = w_cell_handle[g];
        end else begin : g_mid
            assign w_nxt_key    = w_cell_key[g+1];
            assign w_nxt_handle = w_cell_handle[g+1];
        end

        assign w_ctrl[g].cmp_en    = w_accept;
        assign w_ctrl[g].load_ins  = w_do_ins && (r_count == CNT_W'(g));
        assign w_ctrl[g].load_next = w_do_rem && r_mode && w_from_hit[g]
                                     && (CNT_W'(g + 1) < r_count);
        assign w_ctrl[g].load_last = w_do_rem && !r_mode && w_first[g];

        ukt_cell #(
            .HS_W (HS_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl[g]),
            .i_occupied    (CNT_W'(g) < r_count),
            .i_cmp_key     (i_key),
            .i_ins_key     (r_key),
            .i_ins_handle  (r_handle),
            .i_next_key    (w_nxt_key),
            .i_next_handle (w_nxt_handle),
            .i_last_key    (w_cell_key[w_last_idx]),
            .i_last_handle (w_cell_handle[w_last_idx]),
            .o_key         (w_cell_key[g]),
            .o_handle      (w_cell_handle[g]),
            .o_match       (w_match[g])
        );
    end

    // Sequencer and result formation.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_status  = ST_OK;
        n_pos     = '0;
        n_ekey    = '0;
        n_ehandle = '0;
        n_fill    = r_count;
        n_last    = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx   = '0;
                    n_state = (t_req'(i_req_type) == REQ_LIST) ? S_LIST : S_EXEC;
                end
            end
            S_EXEC: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                unique case (r_req)
                    REQ_INSERT: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_pos     = IDX_W'(r_count);
                            n_ekey    = r_key;
                            n_ehandle = r_handle;
                            n_count   = r_count + CNT_W'(1);
                            n_fill    = n_count;
                        end
                    end
                    REQ_LOOKUP, REQ_REMOVE: begin
                        if (!w_hit) begin
                            n_status = ST_NOTFOUND;
                        end else begin
                            n_pos     = w_pos;
                            n_ekey    = w_cell_key[w_rd_idx];
                            n_ehandle = w_cell_handle[w_rd_idx];
                            if (r_req == REQ_REMOVE) begin
                                n_count = r_count - CNT_W'(1);
                                n_fill  = n_count;
                            end
                        end
                    end
                    default: begin
                        n_status = ST_EMPTY;
                    end
                endcase
            end
            S_LIST: begin
                n_valid = 1'b1;
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                    n_state  = S_IDLE;
                end else begin
                    n_pos     = r_idx;
                    n_ekey    = w_cell_key[w_rd_idx];
                    n_ehandle = w_cell_handle[w_rd_idx];
                    n_last    = (r_idx == w_last_idx);
                    n_idx     = r_idx + IDX_W'(1);
                    if (n_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req    <= t_req'(i_req_type);
            r_key    <= i_key;
            r_handle <= HS_W'(i_record_handle);
        end
        r_status  <= n_status;
        r_pos     <= n_pos;
        r_ekey    <= n_ekey;
        r_ehandle <= n_ehandle;
        r_fill    <= n_fill;
        r_last    <= n_last;
    end

    // Removal mode register.
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (w_cfg_wr) begin
            r_mode <= pwdata[0];
        end
    end

    assign prdata = {{(APB_DATA_W-1){1'b0}}, r_mode};
    assign pready = 1'b1;

    // Output ports.
    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_position     = POS_W'(r_pos);
    assign o_entry_key    = r_ekey;
    assign o_entry_handle = HANDLE_PORT_W'(r_ehandle);
    assign o_fill_count   = FILL_W'(r_fill);
    assign o_last         = r_last;

    // Checks on the sequencer and the fill count.
    `UKT_ASSERT_IMP(a_count_range, 1'b1, r_count <= CNT_W'(CAPACITY), "fill count above capacity")
    `UKT_ASSERT_IMP(a_full_status, r_valid && (r_status == ST_FULL), w_full, "full status with room")
    `UKT_ASSERT_NXT(a_end_marked, (r_state != S_IDLE) && (n_state == S_IDLE), r_valid && r_last, "request ended without a last beat")
    `UKT_ASSERT_IMP(a_list_index, (r_state == S_LIST) && (r_count != '0), CNT_W'(r_idx) < r_count, "list index past the fill count")

endmodule

FILE: sim/unordered_key_table_unit_test.sv
// ----------------------------------------------------------------------------
// Unordered key table unit testbench
// Drives insert, lookup, remove and list requests through the command port,
// with the removal mode changed over the APB port between phases. A shadow
// copy of the table predicts every result beat, and the monitor checks each
// beat field by field in arrival order.
// ----------------------------------------------------------------------------
module unordered_key_table_unit_test;
    import ukt_pkg::*;

    localparam int TABLE_DEPTH    = DEF_CAPACITY;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int POOL_SIZE      = 12;
    localparam int PRINT_LIMIT    = 40;

    localparam logic [APB_ADDR_W-1:0] ADDR_REMOVAL_MODE = '0;
    localparam logic MODE_SWAP  = 1'b0;
    localparam logic MODE_SHIFT = 1'b1;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // One request beat, plus a flag that forbids an idle cycle before it.
    typedef struct packed {
        t_req                     req;
        logic signed [KEY_W-1:0]  key;
        logic [HANDLE_PORT_W-1:0] handle;
        logic                     no_gap;
    } t_req_beat;

    // One result beat as the table should produce it.
    typedef struct packed {
        t_status                  status;
        logic [POS_W-1:0]         position;
        logic signed [KEY_W-1:0]  key;
        logic [HANDLE_PORT_W-1:0] handle;
        logic [FILL_W-1:0]        fill;
        logic                     last;
    } t_table_answer;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_start = 1'b0;
    logic [REQ_W-1:0]         i_req_type = '0;
    logic signed [KEY_W-1:0]  i_key = '0;
    logic [HANDLE_PORT_W-1:0] i_record_handle = '0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0]    pwdata = '0;

    logic                     o_busy;
    logic                     o_valid;
    logic [STATUS_W-1:0]      o_status;
    logic [POS_W-1:0]         o_position;
    logic signed [KEY_W-1:0]  o_entry_key;
    logic [HANDLE_PORT_W-1:0] o_entry_handle;
    logic [FILL_W-1:0]        o_fill_count;
    logic                     o_last;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    // Stimulus waiting to be driven and result beats waiting to arrive.
    t_req_beat     request_queue[$];
    t_table_answer table_answers[$];

    // Shadow copy of the table contents and its removal mode.
    logic signed [KEY_W-1:0]  shadow_keys[TABLE_DEPTH];
    logic [HANDLE_PORT_W-1:0] shadow_handles[TABLE_DEPTH];
    int                       shadow_fill = 0;
    logic                     shadow_mode = MODE_SWAP;

    logic signed [KEY_W-1:0]  key_pool[POOL_SIZE];
    int                       mismatch_count = 0;
    int                       stall_cycles = 0;

    unordered_key_table_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_req_type      (i_req_type),
        .i_key           (i_key),
        .i_record_handle (i_record_handle),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_position      (o_position),
        .o_entry_key     (o_entry_key),
        .o_entry_handle  (o_entry_handle),
        .o_fill_count    (o_fill_count),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #6 i_clk = ~i_clk;

    // Print one line per mismatch, up to a limit, and count every one.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        end
    endtask

    // Apply one accepted request to the shadow table and queue its results.
    task automatic apply_table_request(input t_req_beat rq);
        t_table_answer ans;
        int            hit;
        ans = '0;
        ans.status = ST_OK;
        ans.last = 1'b1;
        hit = -1;
        if (rq.req == REQ_LOOKUP || rq.req == REQ_REMOVE) begin
            for (int i = 0; i < shadow_fill; i++) begin
                if (hit < 0 && shadow_keys[i] == rq.key) begin
                    hit = i;
                end
            end
        end
        case (rq.req)
            REQ_INSERT: begin
                if (shadow_fill >= TABLE_DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    shadow_keys[shadow_fill] = rq.key;
                    shadow_handles[shadow_fill] = rq.handle;
                    ans.position = POS_W'(shadow_fill);
                    ans.key = rq.key;
                    ans.handle = rq.handle;
                    shadow_fill++;
                end
                ans.fill = FILL_W'(shadow_fill);
                table_answers.push_back(ans);
            end
            REQ_LOOKUP, REQ_REMOVE: begin
                if (hit < 0) begin
                    ans.status = ST_NOTFOUND;
                end else begin
                    ans.position = POS_W'(hit);
                    ans.key = shadow_keys[hit];
                    ans.handle = shadow_handles[hit];
                    if (rq.req == REQ_REMOVE) begin
                        // Close the gap: swap in the last entry, or shift down.
                        if (shadow_mode == MODE_SWAP) begin
                            shadow_keys[hit] = shadow_keys[shadow_fill - 1];
                            shadow_handles[hit] = shadow_handles[shadow_fill - 1];
                        end else begin
                            for (int i = hit; i + 1 < shadow_fill; i++) begin
                                shadow_keys[i] = shadow_keys[i + 1];
                                shadow_handles[i] = shadow_handles[i + 1];
                            end
                        end
                        shadow_fill--;
                    end
                end
                ans.fill = FILL_W'(shadow_fill);
                table_answers.push_back(ans);
            end
            default: begin
                if (shadow_fill == 0) begin
                    ans.status = ST_EMPTY;
                    table_answers.push_back(ans);
                end else begin
                    for (int i = 0; i < shadow_fill; i++) begin
                        ans.position = POS_W'(i);
                        ans.key = shadow_keys[i];
                        ans.handle = shadow_handles[i];
                        ans.fill = FILL_W'(shadow_fill);
                        ans.last = (i + 1 == shadow_fill);
                        table_answers.push_back(ans);
                    end
                end
            end
        endcase
    endtask

    // Driver: present the next queued request once the current beat is taken.
    always @(posedge i_clk) begin
        t_req_beat nxt;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || !o_busy) begin
            if (request_queue.size() != 0 &&
                (request_queue[0].no_gap || $urandom_range(0, 99) >= 8)) begin
                nxt = request_queue.pop_front();
                i_req_type <= nxt.req;
                i_key <= nxt.key;
                i_record_handle <= nxt.handle;
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: check arriving result beats, then predict for accepted requests.
    always @(posedge i_clk) begin
        t_table_answer want;
        t_req_beat     seen;
        logic          took;
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            took = i_start && !o_busy;
            if (o_valid) begin
                if (table_answers.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 64'(o_status),
                                    64'(0));
                end else begin
                    want = table_answers.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 64'(o_status), 64'(want.status));
                    if (o_position !== want.position)
                        report_mismatch("position", 64'(o_position), 64'(want.position));
                    if (o_entry_key !== want.key)
                        report_mismatch("entry_key", 64'(o_entry_key), 64'(want.key));
                    if (o_entry_handle !== want.handle)
                        report_mismatch("entry_handle", 64'(o_entry_handle),
                                        64'(want.handle));
                    if (o_fill_count !== want.fill)
                        report_mismatch("fill_count", 64'(o_fill_count), 64'(want.fill));
                    if (o_last !== want.last)
                        report_mismatch("last", 64'(o_last), 64'(want.last));
                end
            end
            if (took) begin
                seen = '0;
                seen.req = t_req'(i_req_type);
                seen.key = i_key;
                seen.handle = i_record_handle;
                apply_table_request(seen);
            end
            // Watchdog on cycles with neither a request nor a result beat.
            if (took || o_valid) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("unordered_key_table_unit verification failed");
                $finish;
            end
        end
    end

    task automatic queue_request(input t_req req, input logic signed [KEY_W-1:0] key,
                                 input logic [HANDLE_PORT_W-1:0] handle,
                                 input logic no_gap);
        t_req_beat rq;
        rq.req = req;
        rq.key = key;
        rq.handle = handle;
        rq.no_gap = no_gap;
        request_queue.push_back(rq);
    endtask

    // Keys mostly come from a small pool so lookups and removes find matches.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        end
        if (r < 80) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    function automatic logic [HANDLE_PORT_W-1:0] pick_handle();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            default: return HANDLE_PORT_W'($urandom);
        endcase
    endfunction

    // Queue a random mix; the first quiet_n requests are sent without gaps.
    task automatic queue_random_requests(input int n, input int ins_pct,
                                         input int lkp_pct, input int rem_pct,
                                         input int quiet_n);
        int   r;
        t_req req;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) req = REQ_INSERT;
            else if (r < ins_pct + lkp_pct) req = REQ_LOOKUP;
            else if (r < ins_pct + lkp_pct + rem_pct) req = REQ_REMOVE;
            else req = REQ_LIST;
            queue_request(req, pick_key(), pick_handle(), i < quiet_n);
        end
    endtask

    // Wait until no request is pending and every result beat has arrived.
    task automatic wait_table_idle();
        do @(negedge i_clk);
        while (request_queue.size() != 0 || i_start || table_answers.size() != 0 || o_busy);
        repeat (4) @(negedge i_clk);
    endtask

    // APB write of the removal mode: setup cycle, then access cycle.
    task automatic write_removal_mode(input logic mode);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_REMOVAL_MODE;
        pwdata <= {{(APB_DATA_W - 1){1'b0}}, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_mode = mode;
    endtask

    // Sequence: reset, directed requests, then random phases in both modes.
    initial begin
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, duplicates, first match, swap removal and last entry.
        queue_request(REQ_LIST, 0, '0, 1'b0);
        queue_request(REQ_LOOKUP, 5, '0, 1'b0);
        queue_request(REQ_REMOVE, 5, '0, 1'b0);
        queue_request(REQ_INSERT, KEY_MIN, 16'h0000, 1'b0);
        queue_request(REQ_INSERT, KEY_MAX, 16'hFFFF, 1'b0);
        queue_request(REQ_INSERT, 0, 16'h0001, 1'b0);
        queue_request(REQ_INSERT, -1, 16'h8000, 1'b0);
        queue_request(REQ_INSERT, KEY_MAX, 16'h1234, 1'b0);
        queue_request(REQ_LOOKUP, KEY_MAX, '0, 1'b0);
        queue_request(REQ_LOOKUP, 12345, '0, 1'b0);
        queue_request(REQ_REMOVE, 12345, '0, 1'b0);
        queue_request(REQ_LIST, 0, '0, 1'b0);
        queue_request(REQ_REMOVE, KEY_MIN, '0, 1'b0);
        queue_request(REQ_LIST, 0, '0, 1'b0);
        queue_request(REQ_REMOVE, -1, '0, 1'b0);
        queue_request(REQ_LIST, 0, '0, 1'b0);
        queue_request(REQ_LOOKUP, KEY_MAX, '0, 1'b0);
        queue_request(REQ_REMOVE, KEY_MAX, '0, 1'b0);
        queue_request(REQ_REMOVE, KEY_MAX, '0, 1'b0);
        queue_request(REQ_REMOVE, 0, '0, 1'b0);
        queue_request(REQ_LIST, 0, '0, 1'b0);
        wait_table_idle();

        // Fill up past capacity with shifting removal.
        write_removal_mode(MODE_SHIFT);
        queue_random_requests(120, 60, 15, 15, 0);
        wait_table_idle();

        // Balanced mix with swap removal, opening with a gap-free stretch.
        write_removal_mode(MODE_SWAP);
        queue_random_requests(120, 35, 20, 35, 80);
        wait_table_idle();

        // Drain toward empty with shifting removal.
        write_removal_mode(MODE_SHIFT);
        queue_random_requests(80, 20, 15, 55, 0);
        wait_table_idle();

        write_removal_mode(MODE_SWAP);
        queue_random_requests(40, 50, 20, 20, 0);
        wait_table_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (table_answers.size() != 0) begin
            report_mismatch("result beats never arrived", 64'(0),
                            64'(table_answers.size()));
        end
        if (mismatch_count == 0) begin
            $display("unordered_key_table_unit verification clean");
        end else begin
            $display("unordered_key_table_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ukt_pkg.sv
hdl/ukt_cell.sv
hdl/unordered_key_table_unit.sv
sim/unordered_key_table_unit_test.sv
